// ===== design/rih_pkg.sv =====
`timescale 1ns / 1ps

package rih_pkg;

    localparam int IDX_W       = 32;
    localparam int FRAC_BITS   = 32;
    localparam int BASE_BITS   = 8;
    localparam int DIGIT_STEPS = 8;

    typedef struct packed {
        logic [IDX_W-1:0]     index;
        logic [BASE_BITS-1:0] base;
    } cmd_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] fraction;
        logic                 bad_base;
    } result_t;

endpackage

// ===== design/radical_inverse_halton_unit.sv =====
`timescale 1ns / 1ps

// Halton radical inverse: mirrors the base-b digits of a 32-bit index about the
// radix point and returns floor(value * 2^FRAC_BITS) as an unsigned 0.FRAC_BITS
// fraction. A command beat is taken when start is high and busy is low; busy
// then stays high until the result is shown, for exactly one cycle, with done
// high. The receiver cannot stall: it must take the result in that cycle. One
// shared restoring divider peels off each digit, DIGIT_STEPS quotient bits per
// cycle, and one shared multiplier updates the mirrored value and the scale.
// Each digit takes a divide phase and then two multiply steps; after the last
// digit, a restoring division of the mirrored value by the scale yields the
// fraction bits. A zero index or a base below 2 skips the digit loop; a base
// below 2 returns fraction 0 with bad_base set.
module radical_inverse_halton_unit #(
    parameter int DIGIT_STEPS = rih_pkg::DIGIT_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rih_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output rih_pkg::result_t result
);

    localparam int IDX_W   = rih_pkg::IDX_W;
    localparam int BB      = rih_pkg::BASE_BITS;
    localparam int FB      = rih_pkg::FRAC_BITS;
    localparam int W       = IDX_W + BB;
    localparam int DIG_CYC = IDX_W / DIGIT_STEPS;
    localparam int CNT_MAX = (FB > DIG_CYC) ? FB : DIG_CYC;
    localparam int CNT_W   = (CNT_MAX > 2) ? $clog2(CNT_MAX) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MULM = 5'b00100,
        ST_MULS = 5'b01000,
        ST_FDIV = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [BB-1:0]        base_reg, base_next;
    logic [BB-1:0]        rem_reg, rem_next;
    logic [W-1:0]         mir_reg, mir_next;
    logic [W-1:0]         scale_reg, scale_next;
    logic [FB-1:0]        quo_reg, quo_next;
    logic                 bad_reg, bad_next;
    logic                 done_reg, done_next;
    rih_pkg::result_t     result_reg, result_next;

    logic [BB:0]          div_r;
    logic [IDX_W-1:0]     div_q;
    logic [W-1:0]         mul_a;
    logic [W+BB-1:0]      mul_p;
    logic [W:0]           fd_r;
    logic [W:0]           fd_d;
    logic                 fd_ge;
    logic                 bad_in;

    assign bad_in = (cmd.base < BB'(2));

    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = idx_reg;
        for (int i = 0; i < DIGIT_STEPS; i++)
        begin
            div_r = {div_r[BB-1:0], div_q[IDX_W-1]};
            div_q = {div_q[IDX_W-2:0], 1'b0};
            if (div_r >= {1'b0, base_reg})
            begin
                div_r    = div_r - {1'b0, base_reg};
                div_q[0] = 1'b1;
            end
        end
    end

    assign mul_a = (state_reg == ST_MULM) ? mir_reg : scale_reg;
    assign mul_p = mul_a * base_reg;

    assign fd_r  = {mir_reg, 1'b0};
    assign fd_d  = {1'b0, scale_reg};
    assign fd_ge = (fd_r >= fd_d);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        mir_next    = mir_reg;
        scale_next  = scale_reg;
        quo_next    = quo_reg;
        bad_next    = bad_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next   = cmd.index;
                    base_next  = cmd.base;
                    bad_next   = bad_in;
                    rem_next   = '0;
                    mir_next   = '0;
                    scale_next = W'(1);
                    quo_next   = '0;
                    if (bad_in || (cmd.index == '0))
                    begin
                        cnt_next   = CNT_W'(FB - 1);
                        state_next = ST_FDIV;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(DIG_CYC - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                idx_next = div_q;
                rem_next = div_r[BB-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_MULM;
                end
            end
            ST_MULM:
            begin
                mir_next   = mul_p[W-1:0] + W'(rem_reg);
                state_next = ST_MULS;
            end
            ST_MULS:
            begin
                scale_next = mul_p[W-1:0];
                rem_next   = '0;
                if (idx_reg == '0)
                begin
                    cnt_next   = CNT_W'(FB - 1);
                    state_next = ST_FDIV;
                end
                else
                begin
                    cnt_next   = CNT_W'(DIG_CYC - 1);
                    state_next = ST_DIV;
                end
            end
            ST_FDIV:
            begin
                mir_next = fd_ge ? W'(fd_r - fd_d) : fd_r[W-1:0];
                quo_next = {quo_reg[FB-2:0], fd_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    done_next            = 1'b1;
                    result_next.fraction = quo_next;
                    result_next.bad_base = bad_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        mir_reg    <= mir_next;
        scale_reg  <= scale_next;
        quo_reg    <= quo_next;
        bad_reg    <= bad_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/rih_checker.sv =====
`timescale 1ns / 1ps

module rih_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input rih_pkg::result_t result
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command beat not followed by busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats back to back");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_base) |-> (result.fraction == '0))
        else $error("bad base with nonzero fraction");

endmodule

bind radical_inverse_halton_unit rih_checker u_rih_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== verif/tb_radical_inverse_halton_unit.sv =====
`timescale 1ns / 1ps

module tb_radical_inverse_halton_unit;

    import rih_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        cmd_t    cmd;
        result_t res;
    } halton_expect_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    halton_expect_t expected_beats[$];
    int mismatch_count;
    int idle_cycles;
    int burst_left;

    radical_inverse_halton_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t halton_fraction(input cmd_t c);
        logic [63:0] n;
        logic [63:0] b;
        logic [63:0] mirrored;
        logic [63:0] scale;
        logic [63:0] rem;
        result_t     r;
        n = 64'(c.index);
        b = 64'(c.base);
        mirrored = '0;
        scale = 64'd1;
        r.fraction = '0;
        r.bad_base = 1'b0;
        if (b < 64'd2)
        begin
            r.bad_base = 1'b1;
            return r;
        end
        while (n != 0)
        begin
            mirrored = mirrored * b + (n % b);
            scale = scale * b;
            n = n / b;
        end
        rem = mirrored;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            r.fraction = {r.fraction[FRAC_BITS-2:0], 1'b0};
            if (rem >= scale)
            begin
                rem = rem - scale;
                r.fraction[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [BASE_BITS-1:0] b);
        int unsigned mode;
        int unsigned k;
        logic [63:0] p;
        mode = $urandom_range(0, 99);
        if (mode < 45)
            return $urandom;
        if (mode < 65)
            return $urandom_range(0, 1000);
        if (mode < 75)
            return 32'd1 << $urandom_range(0, 31);
        if (mode < 80)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        if (b < 2)
            return $urandom;
        p = 64'd1;
        k = $urandom_range(1, 32);
        while (k > 0 && p * b <= 64'h1_0000_0000)
        begin
            p = p * b;
            k--;
        end
        case ($urandom_range(0, 2))
            0: return p[IDX_W-1:0];
            1: return p[IDX_W-1:0] - 1'b1;
            default: return p[IDX_W-1:0] + 1'b1;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [IDX_W-1:0] idx, input logic [BASE_BITS-1:0] b);
        cmd_t           c;
        halton_expect_t e;
        int unsigned    gap;
        c.index = idx;
        c.base = b;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        e.cmd = c;
        e.res = halton_fraction(c);
        expected_beats.push_back(e);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 240) : $urandom_range(1, 8);
            start <= 1'b0;
            cmd <= {$urandom, 8'($urandom)};
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
        end
    endtask

    task automatic test_directed();
        send_item(32'd0, 8'd2);
        send_item(32'd0, 8'd255);
        send_item(32'd0, 8'd0);
        send_item(32'd0, 8'd1);
        send_item(32'd1, 8'd2);
        send_item(32'd1, 8'd255);
        send_item(32'hFFFF_FFFF, 8'd2);
        send_item(32'hFFFF_FFFF, 8'd3);
        send_item(32'hFFFF_FFFF, 8'd255);
        send_item(32'hFFFF_FFFF, 8'd0);
        send_item(32'hFFFF_FFFF, 8'd1);
        send_item(32'h8000_0000, 8'd2);
        send_item(32'h7FFF_FFFF, 8'd2);
        send_item(32'd3486784401, 8'd3);
        send_item(32'd3486784400, 8'd3);
        send_item(32'd4228250625, 8'd255);
        send_item(32'd4228250624, 8'd255);
        send_item(32'd12345, 8'd1);
        send_item(32'd5, 8'd128);
        send_item(32'hAAAA_AAAA, 8'd5);
        send_item(32'h5555_5555, 8'd7);
        send_item(32'd256, 8'd16);
        send_item(32'd6, 8'd4);
    endtask

    task automatic test_small_bases(input int count);
        logic [BASE_BITS-1:0] b;
        repeat (count)
        begin
            b = 8'($urandom_range(2, 13));
            send_item(pick_index(b), b);
        end
    endtask

    task automatic test_wide_bases(input int count);
        logic [BASE_BITS-1:0] b;
        repeat (count)
        begin
            b = 8'($urandom_range(2, 255));
            send_item(pick_index(b), b);
        end
    endtask

    task automatic test_mixed_bad_bases(input int count);
        logic [BASE_BITS-1:0] b;
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                b = 8'($urandom_range(0, 1));
            else
                b = 8'($urandom);
            send_item(pick_index(b), b);
        end
    endtask

    always @(posedge clk)
    begin
        halton_expect_t e;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("result with none pending: fraction=%h bad_base=%b",
                                          result.fraction, result.bad_base));
            else
            begin
                e = expected_beats.pop_front();
                if (result.fraction !== e.res.fraction)
                    report_mismatch($sformatf("index=%h base=%0d fraction got %h want %h",
                                              e.cmd.index, e.cmd.base,
                                              result.fraction, e.res.fraction));
                if (result.bad_base !== e.res.bad_base)
                    report_mismatch($sformatf("index=%h base=%0d bad_base got %b want %b",
                                              e.cmd.index, e.cmd.base,
                                              result.bad_base, e.res.bad_base));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        burst_left = 3;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_small_bases(400);
        test_wide_bases(600);
        test_mixed_bad_bases(400);
        @(posedge clk);
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
